// ----- src/v3n_pkg.sv -----
// Shared constants and types for the vector normalize block.
// No dependencies; imported by vector3_normalize_with_length.
package v3n_pkg;

	localparam int CompW     = 32;
	localparam int SqrtSteps = 32;
	localparam int DivSteps  = 31;
	localparam int RadW      = 2 * CompW;
	localparam int RemW      = CompW + 3;
	localparam logic [CompW-1:0] OneQ30 = 32'h4000_0000;

	// Component magnitudes and signs carried down the pipeline
	typedef struct packed {
		logic [2:0]            neg;
		logic [2:0][CompW-1:0] mag;
	} comp_t;

endpackage

// ----- src/vector3_normalize_with_length.sv -----
// Normalizes one Q16.16 3D vector per word to Q2.30 and returns its Q16.16 length.
// Depends on v3n_pkg (constants and the comp_t carry struct).
//
// Usage:
//   Input channel vec_* carries one vector word (vec_x, vec_y, vec_z). Output
//   channel unit_* carries unit_x/y/z, magnitude and zero_vector. A word moves on
//   a rising edge where valid is high and stall is low.
//   From accept to result a word passes through magnitude, square, sum, 32
//   square root stages (one root bit each) and 31 divider stages (one quotient
//   bit each, three dividers side by side), then the output register.
//   Throughput is one word per cycle while the receiver does not stall; the square
//   root and divider are fully unrolled into stages, so a new word enters every cycle unless vec_stall is high.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   vec_stall rises in the same cycle; no word is lost or repeated.
//   A zero vector gives zero components, magnitude 0 and zero_vector high.
//   Reset (arst_n low) clears all valid bits; data registers are not reset.
module vector3_normalize_with_length (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       vec_valid,
	output logic                       vec_stall,
	input  logic signed [v3n_pkg::CompW-1:0] vec_x,
	input  logic signed [v3n_pkg::CompW-1:0] vec_y,
	input  logic signed [v3n_pkg::CompW-1:0] vec_z,
	output logic                       unit_valid,
	input  logic                       unit_stall,
	output logic signed [v3n_pkg::CompW-1:0] unit_x,
	output logic signed [v3n_pkg::CompW-1:0] unit_y,
	output logic signed [v3n_pkg::CompW-1:0] unit_z,
	output logic        [v3n_pkg::CompW-1:0] magnitude,
	output logic                       zero_vector
);
	import v3n_pkg::*;

	logic en;
	logic [2:0][CompW-1:0] vin;

	logic                  v_s1, v_s2, v_s3;
	comp_t                 comp_s1, comp_s2, comp_s3;
	logic [2:0][RadW-1:0]  sq_s2;
	logic [RadW-1:0]       sum_s3;

	// square root stages, index 0 is fed from s3
	logic              sq_v    [SqrtSteps+1];
	logic [RadW-1:0]   sq_rad  [SqrtSteps+1];
	logic [RemW-1:0]   sq_rem  [SqrtSteps+1];
	logic [CompW-1:0]  sq_root [SqrtSteps+1];
	comp_t             sq_comp [SqrtSteps+1];

	// divider stages, index 0 is fed from the last root stage
	logic                      dv_v    [DivSteps+1];
	logic [CompW-1:0]          dv_len  [DivSteps+1];
	logic [2:0]                dv_neg  [DivSteps+1];
	logic [2:0][CompW-1:0]     dv_rem  [DivSteps+1];
	logic [2:0][DivSteps-1:0]  dv_nq   [DivSteps+1];

	assign en        = !(unit_valid && unit_stall);
	assign vec_stall = !en;
	assign vin[0]    = vec_x;
	assign vin[1]    = vec_y;
	assign vin[2]    = vec_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= vec_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				comp_s1.neg[i] <= vin[i][CompW-1];
				comp_s1.mag[i] <= vin[i][CompW-1] ? (~vin[i] + 1'b1) : vin[i];
				sq_s2[i]       <= comp_s1.mag[i] * comp_s1.mag[i];
			end
			comp_s2 <= comp_s1;
			comp_s3 <= comp_s2;
			sum_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		end
	end

	assign sq_v[0]    = v_s3;
	assign sq_rad[0]  = sum_s3;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_comp[0] = comp_s3;

	for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
		logic [RemW-1:0] cand, trial, diff;
		logic            ge;
		always_comb begin
			cand  = {sq_rem[k][RemW-3:0], sq_rad[k][RadW-1 -: 2]};
			trial = {1'b0, sq_root[k], 2'b01};
			diff  = cand - trial;
			ge    = (cand >= trial);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k+1] <= 1'b0;
			end else if (en) begin
				sq_v[k+1] <= sq_v[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_rad[k+1]  <= sq_rad[k] << 2;
				sq_rem[k+1]  <= ge ? diff : cand;
				sq_root[k+1] <= {sq_root[k][CompW-2:0], ge};
				sq_comp[k+1] <= sq_comp[k];
			end
		end
	end

	// seed the dividers: numerator is mag << 30, top part mag >> 1 is below len
	assign dv_v[0]   = sq_v[SqrtSteps];
	assign dv_len[0] = sq_root[SqrtSteps];
	assign dv_neg[0] = sq_comp[SqrtSteps].neg;
	for (genvar i = 0; i < 3; i++) begin : g_seed
		assign dv_rem[0][i] = {1'b0, sq_comp[SqrtSteps].mag[i][CompW-1:1]};
		assign dv_nq[0][i]  = {sq_comp[SqrtSteps].mag[i][0], {(DivSteps-1){1'b0}}};
	end

	for (genvar j = 0; j < DivSteps; j++) begin : g_div
		logic [2:0][CompW:0] cand, diff;
		logic [2:0]          ge;
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				cand[i] = {dv_rem[j][i], dv_nq[j][i][DivSteps-1]};
				diff[i] = cand[i] - {1'b0, dv_len[j]};
				ge[i]   = (cand[i] >= {1'b0, dv_len[j]});
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j+1] <= 1'b0;
			end else if (en) begin
				dv_v[j+1] <= dv_v[j];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_len[j+1] <= dv_len[j];
				dv_neg[j+1] <= dv_neg[j];
				for (int i = 0; i < 3; i++) begin
					dv_rem[j+1][i] <= ge[i] ? diff[i][CompW-1:0] : cand[i][CompW-1:0];
					dv_nq[j+1][i]  <= {dv_nq[j][i][DivSteps-2:0], ge[i]};
				end
			end
		end
	end

	logic                  zero_fin;
	logic [2:0][CompW-1:0] q_fin, res_fin;

	always_comb begin
		zero_fin = (dv_len[DivSteps] == '0);
		for (int i = 0; i < 3; i++) begin
			q_fin[i] = {1'b0, dv_nq[DivSteps][i]};
			if (q_fin[i] > OneQ30) begin
				q_fin[i] = OneQ30;
			end
			res_fin[i] = dv_neg[DivSteps][i] ? (~q_fin[i] + 1'b1) : q_fin[i];
			if (zero_fin) begin
				res_fin[i] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_valid <= 1'b0;
		end else if (en) begin
			unit_valid <= dv_v[DivSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unit_x      <= res_fin[0];
			unit_y      <= res_fin[1];
			unit_z      <= res_fin[2];
			magnitude   <= dv_len[DivSteps];
			zero_vector <= zero_fin;
		end
	end

	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && zero_vector |->
			magnitude == '0 && unit_x == '0 && unit_y == '0 && unit_z == '0)
		else $error("zero vector result carries nonzero data");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && !zero_vector |-> magnitude != '0)
		else $error("nonzero vector with zero length");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid |-> unit_x <= $signed(OneQ30) && unit_x >= -$signed(OneQ30)
			&& unit_y <= $signed(OneQ30) && unit_y >= -$signed(OneQ30)
			&& unit_z <= $signed(OneQ30) && unit_z >= -$signed(OneQ30))
		else $error("unit component out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s3) && $stable(sum_s3) && $stable(dv_len[DivSteps]))
		else $error("pipeline moved during stall");

endmodule

// ----- verif/tb_vector3_normalize_with_length.sv -----
// Testbench for vector3_normalize_with_length: drives vector words, predicts the
// unit vector and length per word, and checks each result word in order.
// Depends on v3n_pkg and the block under test.
`timescale 1ns / 1ps

class norm_scoreboard;
	typedef struct {
		logic [31:0] ux, uy, uz, len;
		logic        zero;
	} norm_word_t;

	norm_word_t pending[$];
	int mismatches = 0;

	static function logic [63:0] abs32(logic [31:0] v);
		return v[31] ? (64'h1_0000_0000 - {32'b0, v}) : {32'b0, v};
	endfunction

	static function logic [63:0] root64(logic [63:0] v);
		logic [63:0] rem, root, b;
		rem = v;
		root = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem = rem - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	static function logic [31:0] scale(logic [31:0] c, logic [63:0] len);
		logic [63:0] q;
		q = (abs32(c) << 30) / len;
		if (q > 64'h4000_0000) q = 64'h4000_0000;
		if (c[31]) q = 64'd0 - q;
		return q[31:0];
	endfunction

	function void note_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		norm_word_t w;
		logic [63:0] ax, ay, az, sum, len;
		ax = abs32(x);
		ay = abs32(y);
		az = abs32(z);
		sum = ax * ax + ay * ay + az * az;
		if (sum == 0) begin
			w = '{32'd0, 32'd0, 32'd0, 32'd0, 1'b1};
		end else begin
			len = root64(sum);
			w = '{scale(x, len), scale(y, len), scale(z, len), len[31:0], 1'b0};
		end
		pending.push_back(w);
	endfunction

	function void check_unit(logic [31:0] ux, logic [31:0] uy, logic [31:0] uz,
			logic [31:0] len, logic zero);
		norm_word_t w;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result word");
			return;
		end
		w = pending.pop_front();
		if (ux !== w.ux || uy !== w.uy || uz !== w.uz || len !== w.len || zero !== w.zero) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp %h %h %h %h %b got %h %h %h %h %b",
					w.ux, w.uy, w.uz, w.len, w.zero, ux, uy, uz, len, zero);
		end
	endfunction
endclass

module tb_vector3_normalize_with_length;
	import v3n_pkg::*;

	localparam int Latency = 67;
	localparam int CycleLimit = 400000;

	logic clk = 0, arst_n = 0;
	logic vec_valid = 0, unit_stall = 0;
	logic signed [CompW-1:0] vec_x = 0, vec_y = 0, vec_z = 0;
	logic vec_stall, unit_valid, zero_vector;
	logic signed [CompW-1:0] unit_x, unit_y, unit_z;
	logic [CompW-1:0] magnitude;

	norm_scoreboard board = new();
	int cycles = 0;

	vector3_normalize_with_length dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("tb_vector3_normalize_with_length failed");
			$finish;
		end
	end

	// Check result words and stall on a pattern of its own
	int stall_mode = 0;
	always @(posedge clk) begin
		if (arst_n && unit_valid && !unit_stall)
			board.check_unit(unit_x, unit_y, unit_z, magnitude, zero_vector);
		if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: unit_stall <= 1'b0;
			1: unit_stall <= ($urandom_range(0, 3) == 0);
			2: unit_stall <= ($urandom_range(0, 1) == 0);
			default: unit_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	int burst_left = 0;

	// Present one word, after a random idle gap at the start of a burst, and hold it until accepted
	task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
			if (gap > 0) begin
				vec_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		vec_valid <= 1'b1;
		vec_x <= x;
		vec_y <= y;
		vec_z <= z;
		@(posedge clk);
		while (vec_stall) @(posedge clk);
		board.note_vector(x, y, z);
		burst_left--;
	endtask

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 255) - 128;
			2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
			3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
			4: return 32'd0;
			default: return $urandom() >> $urandom_range(0, 31);
		endcase
	endfunction

	logic [31:0] corners[6] = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff,
		32'h8000_0000, 32'h0001_0000};

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: zero vector, extremes, single axes, a 3-4-5 vector and a mixed-sign vector
		send_vector(0, 0, 0);
		send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		for (int i = 1; i < 6; i++) begin
			send_vector(corners[i], 0, 0);
			send_vector(0, corners[i], 0);
			send_vector(0, 0, corners[i]);
		end
		send_vector(32'h0003_0000, 32'h0004_0000, 0);
		send_vector(32'hffff_ffff, 32'h1, 32'h8000_0000);
		for (int i = 0; i < 1900; i++) begin
			if (i == 900) begin
				// Drain everything before continuing
				vec_valid <= 1'b0;
				@(posedge clk);
				while (board.pending.size() != 0) @(posedge clk);
			end
			send_vector(rand_comp(), rand_comp(), rand_comp());
		end
		vec_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (Latency + 10) @(posedge clk);
		if (board.mismatches == 0)
			$display("tb_vector3_normalize_with_length passed");
		else
			$display("tb_vector3_normalize_with_length failed");
		$finish;
	end
endmodule
